/* hdl/tbbs_pkg.sv */
// Shared constants and control/status types for the two-bit block-state bitmap.
package tbbs_pkg;

    localparam int unsigned OP_W            = 2;
    localparam int unsigned BLK_W           = 12;
    localparam int unsigned ST_W            = 2;
    localparam int unsigned VAL_W           = 13;
    localparam int unsigned LEN_W           = 11;
    localparam int unsigned BYTE_W          = 8;
    localparam int unsigned ENTRIES         = 4;
    localparam int unsigned POS_W           = 2;
    localparam int unsigned LEN_MAX         = 2047;
    localparam int unsigned STORE_BYTES_DEF = 1024;

    localparam logic [LEN_W-1:0]  LEN_RESET = 11'd1024;
    localparam logic [BYTE_W-1:0] LOW_BITS  = 8'h55;

    localparam logic [OP_W-1:0] OP_SET   = 2'd0;
    localparam logic [OP_W-1:0] OP_FIND  = 2'd1;
    localparam logic [OP_W-1:0] OP_COUNT = 2'd2;

    typedef struct packed {
        logic clr;
        logic accept;
        logic set_rd;
        logic set_wr;
        logic scan;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic scan_done;
    } t_sts;

endpackage

/* hdl/tbbs_if.sv */
// Request and response channel interfaces with valid/ready handshake.
interface tbbs_req_if;
    import tbbs_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [BLK_W-1:0]  block_index;
    logic [ST_W-1:0]   block_state;

    modport source (output valid, output opcode, output block_index, output block_state,
                    input ready);
    modport sink   (input valid, input opcode, input block_index, input block_state,
                    output ready);
endinterface

interface tbbs_rsp_if;
    import tbbs_pkg::*;

    logic              valid;
    logic              ready;
    logic              found;
    logic [VAL_W-1:0]  result_value;

    modport source (output valid, output found, output result_value, input ready);
    modport sink   (input valid, input found, input result_value, output ready);
endinterface

/* hdl/two_bit_block_state_bitmap_core.sv */
// A set passes through the SET_RD, SET_WR and DONE states; an unused opcode goes straight to DONE.
// Find and count read one bitmap byte per cycle through the memory read port, over the active
// length (the length register capped at the store size); find stops at the first match.
// One transaction is in work at a time; the response register frees the input side.
// Reset: a clearing pass writes zero to every byte, with request ready low; length register
// returns to 1024. Configuration writes are taken at any time.
module two_bit_block_state_bitmap_core #(
    parameter int unsigned STORE_BYTES = tbbs_pkg::STORE_BYTES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [tbbs_pkg::LEN_W-1:0] i_cfg_wr_data,
    tbbs_req_if.sink                   i_req,
    tbbs_rsp_if.source                 o_rsp
);
    import tbbs_pkg::*;

    t_cmd cmd;
    t_sts sts;

    tbbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_opcode    (i_req.opcode),
        .o_req_ready (i_req.ready),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp_valid (o_rsp.valid),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    tbbs_dp #(
        .STORE_BYTES (STORE_BYTES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_opcode       (i_req.opcode),
        .i_block_index  (i_req.block_index),
        .i_block_state  (i_req.block_state),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_found        (o_rsp.found),
        .o_result_value (o_rsp.result_value)
    );

endmodule

/* hdl/tbbs_ctrl.sv */
// Controller state machine: clearing pass, operation sequencing, response handshake.
module tbbs_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_req_valid,
    input  logic [tbbs_pkg::OP_W-1:0] i_opcode,
    output logic                    o_req_ready,
    input  logic                    i_rsp_ready,
    output logic                    o_rsp_valid,
    output tbbs_pkg::t_cmd          o_cmd,
    input  tbbs_pkg::t_sts          i_sts
);
    import tbbs_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SET_RD,
        S_SET_WR,
        S_SCAN,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_rsp_valid, n_rsp_valid;

    always_comb begin
        n_state     = r_state;
        n_rsp_valid = r_rsp_valid && !i_rsp_ready;
        o_cmd       = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.accept = 1'b1;
                    unique case (i_opcode)
                        OP_SET:             n_state = S_SET_RD;
                        OP_FIND, OP_COUNT:  n_state = S_SCAN;
                        default:            n_state = S_DONE;
                    endcase
                end
            end
            S_SET_RD: begin
                o_cmd.set_rd = 1'b1;
                n_state      = S_SET_WR;
            end
            S_SET_WR: begin
                o_cmd.set_wr = 1'b1;
                n_state      = S_DONE;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold the result until the output register is free
                if (!r_rsp_valid || i_rsp_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_rsp_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_rsp_valid;

endmodule

/* hdl/tbbs_dp.sv */
// Datapath: bitmap memory, length register, scan pointer, match logic, result registers.
module tbbs_dp #(
    parameter int unsigned STORE_BYTES = tbbs_pkg::STORE_BYTES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [tbbs_pkg::LEN_W-1:0] i_cfg_wr_data,
    input  logic [tbbs_pkg::OP_W-1:0]  i_opcode,
    input  logic [tbbs_pkg::BLK_W-1:0] i_block_index,
    input  logic [tbbs_pkg::ST_W-1:0]  i_block_state,
    input  tbbs_pkg::t_cmd            i_cmd,
    output tbbs_pkg::t_sts            o_sts,
    output logic                      o_found,
    output logic [tbbs_pkg::VAL_W-1:0] o_result_value
);
    import tbbs_pkg::*;

    localparam int unsigned AW  = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int unsigned CAP = (STORE_BYTES > LEN_MAX) ? LEN_MAX : STORE_BYTES;

    logic [BYTE_W-1:0] r_mem [STORE_BYTES];
    logic [BYTE_W-1:0] r_rd_data;
    logic [AW-1:0]     r_clr_addr;
    logic [LEN_W-1:0]  r_len;

    logic [OP_W-1:0]   r_op;
    logic [BLK_W-1:0]  r_blk;
    logic [ST_W-1:0]   r_want;
    logic [LEN_W-1:0]  r_ptr;
    logic              r_ev_valid;
    logic [LEN_W-1:0]  r_ev_ptr;
    logic              r_res_found;
    logic [VAL_W-1:0]  r_res_value;
    logic              r_out_found;
    logic [VAL_W-1:0]  r_out_value;

    logic [LEN_W-1:0]  alen;
    logic [LEN_W-1:0]  set_byte;
    logic              set_in_range;
    logic [AW-1:0]     rd_addr;
    logic [BYTE_W-1:0] new_byte;
    logic              more;
    logic              issue;
    logic [ENTRIES-1:0] match;
    logic [ENTRIES-1:0] masked;
    logic              skip_ok;
    logic              hit;
    logic [POS_W-1:0]  hit_pos;
    logic [POS_W:0]    match_cnt;

    assign alen         = (r_len > LEN_W'(CAP)) ? LEN_W'(CAP) : r_len;
    assign set_byte     = LEN_W'(r_blk[BLK_W-1:POS_W]);
    assign set_in_range = set_byte < alen;
    assign rd_addr      = i_cmd.set_rd ? AW'(set_byte) : AW'(r_ptr);
    assign more         = r_ptr < alen;

    always_comb begin
        for (int p = 0; p < ENTRIES; p++) begin
            if (POS_W'(p) == r_blk[POS_W-1:0]) begin
                new_byte[2*p +: 2] = r_want;
            end else begin
                new_byte[2*p +: 2] = r_rd_data[2*p +: 2];
            end
        end
    end

    // per-entry compare of the byte under evaluation
    always_comb begin
        match_cnt = '0;
        for (int p = 0; p < ENTRIES; p++) begin
            match[p]  = (r_rd_data[2*p +: 2] == r_want);
            match_cnt = match_cnt + (POS_W+1)'(match[p]);
            if (r_ev_ptr == set_byte) begin
                masked[p] = match[p] && (POS_W'(p) >= r_blk[POS_W-1:0]);
            end else begin
                masked[p] = match[p];
            end
        end
    end

    // a byte whose low bits all disagree with the wanted low bit cannot match
    assign skip_ok = (r_rd_data & LOW_BITS) != (r_want[0] ? '0 : LOW_BITS);
    assign hit     = i_cmd.scan && r_ev_valid && (r_op == OP_FIND) && skip_ok && (|masked);
    assign issue   = i_cmd.scan && more && !hit;

    always_comb begin
        hit_pos = '0;
        for (int p = ENTRIES - 1; p >= 0; p--) begin
            if (masked[p]) begin
                hit_pos = POS_W'(p);
            end
        end
    end

    assign o_sts.clr_last  = (r_clr_addr == AW'(STORE_BYTES - 1));
    assign o_sts.scan_done = hit || (!more && !r_ev_valid);

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_cmd.set_wr && set_in_range) begin
            r_mem[AW'(set_byte)] <= new_byte;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_len      <= LEN_RESET;
            r_ev_valid <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cfg_wr_en) begin
                r_len <= i_cfg_wr_data;
            end
            r_ev_valid <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op        <= i_opcode;
            r_blk       <= i_block_index;
            r_want      <= i_block_state;
            r_ptr       <= (i_opcode == OP_FIND) ? LEN_W'(i_block_index[BLK_W-1:POS_W]) : '0;
            r_res_found <= (i_opcode == OP_SET) || (i_opcode == OP_COUNT);
            r_res_value <= '0;
        end else begin
            if (issue) begin
                r_ptr <= r_ptr + 1'b1;
            end
            if (hit) begin
                r_res_found <= 1'b1;
                r_res_value <= {r_ev_ptr, hit_pos};
            end else if (i_cmd.scan && r_ev_valid && (r_op == OP_COUNT)) begin
                r_res_value <= r_res_value + VAL_W'(match_cnt);
            end
        end
        r_ev_ptr <= r_ptr;
        if (i_cmd.load_out) begin
            r_out_found <= r_res_found;
            r_out_value <= r_res_value;
        end
    end

    assign o_found        = r_out_found;
    assign o_result_value = r_out_value;

endmodule

/* hdl/tbbs_chk.sv */
// Port-level checker for the bitmap core and its bind.
module tbbs_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_req_valid,
    input logic                       i_req_ready,
    input logic                       i_rsp_valid,
    input logic                       i_rsp_ready,
    input logic                       i_rsp_found,
    input logic [tbbs_pkg::VAL_W-1:0] i_rsp_value
);
    import tbbs_pkg::*;

    // the clearing pass follows reset, so no request is taken right after it
    a_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_req_ready)
        else $error("request ready high right after reset");

    // one transaction at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request ready high right after an accepted transaction");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> i_rsp_valid)
        else $error("response dropped while stalled");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_found) |-> (i_rsp_value == '0))
        else $error("response without match carries a nonzero value");

endmodule

bind two_bit_block_state_bitmap_core tbbs_chk u_tbbs_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_found (o_rsp.found),
    .i_rsp_value (o_rsp.result_value)
);

/* bench/tb_two_bit_block_state_bitmap_core.sv */
// Self-checking testbench for the two-bit block-state bitmap core.
module tb_two_bit_block_state_bitmap_core;
    timeunit 1ns;
    timeprecision 1ps;

    import tbbs_pkg::*;

    localparam logic [OP_W-1:0]  OP_UNUSED   = 2'd3;
    localparam int unsigned      COUNT_MAX   = (1 << VAL_W) - 1;
    localparam int unsigned      CYCLE_LIMIT = 4_000_000;
    localparam int unsigned      SCAN_CYCLES = 1100;

    typedef struct packed {
        logic             found;
        logic [VAL_W-1:0] value;
    } t_rsp;

    // Mirror of the bitmap and length register; queues the response of each request.
    class bitmap_scoreboard;
        logic [BYTE_W-1:0] bitmap [STORE_BYTES_DEF];
        logic [LEN_W-1:0]  length_bytes;
        t_rsp              expected_q[$];
        int unsigned       errors;

        function new();
            foreach (bitmap[i]) bitmap[i] = '0;
            length_bytes = LEN_RESET;
            errors       = 0;
        endfunction

        function int unsigned active_bytes();
            return (length_bytes > STORE_BYTES_DEF) ? STORE_BYTES_DEF : length_bytes;
        endfunction

        function logic [ST_W-1:0] block_state_of(int unsigned blk);
            logic [BYTE_W-1:0] byte_v;
            byte_v = bitmap[blk / ENTRIES];
            return byte_v[ST_W * (blk % ENTRIES) +: ST_W];
        endfunction

        function void set_length(logic [LEN_W-1:0] len);
            length_bytes = len;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic [BLK_W-1:0] idx,
                                   logic [ST_W-1:0] st);
            t_rsp              r;
            int unsigned       span;
            int unsigned       b;
            int unsigned       n;
            logic [BYTE_W-1:0] byte_v;
            r    = '0;
            span = ENTRIES * active_bytes();
            case (op)
                OP_SET: begin
                    r.found = 1'b1;
                    // drop writes past the active length
                    if (idx / ENTRIES < active_bytes()) begin
                        byte_v = bitmap[idx / ENTRIES];
                        byte_v[ST_W * (idx % ENTRIES) +: ST_W] = st;
                        bitmap[idx / ENTRIES] = byte_v;
                    end
                end
                OP_FIND: begin
                    for (b = idx; b < span && !r.found; b++) begin
                        if (block_state_of(b) == st) begin
                            r.found = 1'b1;
                            r.value = VAL_W'(b);
                        end
                    end
                end
                OP_COUNT: begin
                    n = 0;
                    for (b = 0; b < span; b++)
                        if (block_state_of(b) == st) n++;
                    r.found = 1'b1;
                    r.value = VAL_W'((n > COUNT_MAX) ? COUNT_MAX : n);
                end
                default: ;
            endcase
            expected_q.push_back(r);
        endfunction

        function void check_response(logic found, logic [VAL_W-1:0] value);
            t_rsp exp_r;
            if (expected_q.size() == 0) begin
                $error("response with none pending: found=%0d result_value=%0d", found, value);
                errors++;
            end else begin
                exp_r = expected_q.pop_front();
                if (found !== exp_r.found) begin
                    $error("found: expected %0d, actual %0d", exp_r.found, found);
                    errors++;
                end
                if (value !== exp_r.value) begin
                    $error("result_value: expected %0d, actual %0d", exp_r.value, value);
                    errors++;
                end
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_wr_en;
    logic [LEN_W-1:0] i_cfg_wr_data;

    tbbs_req_if req_ch ();
    tbbs_rsp_if rsp_ch ();

    two_bit_block_state_bitmap_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_req         (req_ch),
        .o_rsp         (rsp_ch)
    );

    bitmap_scoreboard sb;
    int unsigned      idle_pct;
    int unsigned      stall_pct;
    int unsigned      hold_cycles;
    int unsigned      cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_two_bit_block_state_bitmap_core: FAIL");
        $finish;
    end

    // Response side: held off while hold_cycles runs down, random stall otherwise.
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                rsp_ch.ready <= 1'b0;
                hold_cycles--;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_response(rsp_ch.found, rsp_ch.result_value);
            if (req_ch.valid && req_ch.ready)
                sb.note_request(req_ch.opcode, req_ch.block_index, req_ch.block_state);
        end
    end

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_req(input logic [OP_W-1:0] op, input logic [BLK_W-1:0] idx,
                            input logic [ST_W-1:0] st);
        while ($urandom_range(99) < idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.opcode      <= op;
        req_ch.block_index <= idx;
        req_ch.block_state <= st;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_random();
        int unsigned     pick;
        int unsigned     span;
        logic [OP_W-1:0] op;
        logic [BLK_W-1:0] idx;
        pick = $urandom_range(99);
        if (pick < 50)      op = OP_SET;
        else if (pick < 80) op = OP_FIND;
        else if (pick < 92) op = OP_COUNT;
        else                op = OP_UNUSED;
        span = ENTRIES * sb.active_bytes();
        // mostly aim inside the active region so sets build up state for finds
        if (span != 0 && $urandom_range(99) < 80)
            idx = BLK_W'($urandom_range(span - 1));
        else
            idx = BLK_W'($urandom);
        send_req(op, idx, ST_W'($urandom));
    endtask

    task automatic write_length(input logic [LEN_W-1:0] len);
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= len;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.set_length(len);
    endtask

    task automatic run_phase(input int unsigned n, input logic [LEN_W-1:0] len,
                             input int unsigned idle, input int unsigned stall);
        write_length(len);
        idle_pct  = idle;
        stall_pct = stall;
        repeat (n) send_random();
    endtask

    initial begin
        sb                 = new();
        idle_pct           = 0;
        stall_pct          = 0;
        hold_cycles        = 0;
        i_rst_n            = 1'b0;
        i_cfg_wr_en        = 1'b0;
        i_cfg_wr_data      = '0;
        req_ch.valid       = 1'b0;
        req_ch.opcode      = OP_SET;
        req_ch.block_index = '0;
        req_ch.block_state = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: cleared store at the reset length.
        send_req(OP_COUNT, 12'd0, 2'd0);
        send_req(OP_FIND, 12'd0, 2'd0);
        send_req(OP_FIND, 12'd0, 2'd3);
        send_req(OP_SET, 12'd4095, 2'd3);
        send_req(OP_FIND, 12'd0, 2'd3);
        send_req(OP_SET, 12'd0, 2'd2);
        send_req(OP_FIND, 12'd0, 2'd2);
        send_req(OP_SET, 12'd5, 2'd1);
        send_req(OP_FIND, 12'd1, 2'd1);
        send_req(OP_FIND, 12'd1, 2'd2);
        send_req(OP_COUNT, 12'd4095, 2'd3);
        send_req(OP_UNUSED, 12'd4095, 2'd3);
        // empty active region
        write_length(11'd0);
        send_req(OP_SET, 12'd0, 2'd1);
        send_req(OP_FIND, 12'd0, 2'd0);
        send_req(OP_COUNT, 12'd0, 2'd0);
        // length above the store size
        write_length(11'd2047);
        send_req(OP_COUNT, 12'd0, 2'd2);
        send_req(OP_FIND, 12'd4000, 2'd3);
        send_req(OP_SET, 12'd2049, 2'd3);
        // single byte: goal past the length, set past the length
        write_length(11'd1);
        send_req(OP_FIND, 12'd4, 2'd3);
        send_req(OP_SET, 12'd4, 2'd1);
        send_req(OP_SET, 12'd3, 2'd3);
        send_req(OP_COUNT, 12'd0, 2'd3);

        run_phase(110, LEN_W'($urandom_range(64, 1)), 0, 0);
        run_phase(100, 11'd1, 66, 0);
        run_phase(100, LEN_W'($urandom_range(300, 65)), 0, 66);
        run_phase(60, 11'd2047, 24, 24);

        // Hold the response side off while requests keep coming.
        write_length(11'd16);
        idle_pct    = 0;
        stall_pct   = 0;
        hold_cycles = 300;
        repeat (60) send_random();

        run_phase(130, LEN_W'($urandom_range(64, 1)), 24, 24);
        run_phase(20, 11'd1024, 0, 0);

        req_ch.valid <= 1'b0;
        stall_pct = 0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SCAN_CYCLES) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_two_bit_block_state_bitmap_core: PASS");
        else
            $display("tb_two_bit_block_state_bitmap_core: FAIL");
        $finish;
    end

endmodule
